### hw/rtl/cld_pkg.sv
// Shared types and constants for the command line hash dispatcher.
`default_nettype none

package cld_pkg;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned MAX_PARAMS     = 7;
  localparam int unsigned MAX_NAME_CHARS = 5;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TOK_W  = $clog2(MAX_PARAMS + 2);
  localparam int unsigned CHR_W  = $clog2(MAX_NAME_CHARS + 1);

  localparam logic [31:0] HASH_START   = 32'd5381;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [7:0]  CHAR_TAB     = 8'h09;
  localparam logic [7:0]  TERM_DEFAULT = 8'd10;

  typedef enum logic [2:0] {
    ST_MATCHED    = 3'd0,
    ST_UNKNOWN    = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_REGISTERED = 3'd3,
    ST_REJECTED   = 3'd4
  } status_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  char_value;
    logic [39:0] name_bytes;
    logic [3:0]  name_length;
  } cld_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [2:0]  param_count;
    logic [31:0] command_hash;
  } cld_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    step_char;
    logic    load_line;
    logic    load_reg;
    logic    reg_step;
    logic    scan_clr;
    logic    scan_read;
    logic    scan_inc;
    logic    out_load;
    status_e res_st;
  } cld_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_reg;
    logic is_term;
    logic line_empty;
    logic reg_reject;
    logic table_empty;
    logic reg_done;
    logic scan_hit;
    logic scan_last;
    logic slot_free;
  } cld_sts_t;

  // One djb2 step: h * 33 + c, wrapping
  function automatic logic [31:0] hash_step(logic [31:0] h, logic [7:0] c);
    hash_step = {h[26:0], 5'b00000} + h + {24'd0, c};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cld_dp.sv
// Datapath: line state, hash work register, command table and result register.
`default_nettype none

module cld_dp import cld_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cld_in_t  in_data_i,
  input  wire logic     cfg_valid_i,
  input  wire logic     cfg_ready_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic     out_stall_i,
  input  wire cld_cmd_t cmd_i,
  output cld_sts_t      sts_o,
  output logic          out_valid_o,
  output cld_out_t      out_data_o
);

  logic [7:0]       term_q;
  logic [31:0]      hash_q, hash_d;
  logic [TOK_W-1:0] tok_q, tok_d;
  logic             in_tok_q, in_tok_d;
  logic             zero_q, zero_d;
  logic [CNT_W-1:0] count_q;
  logic [31:0]      work_hash_q;
  logic [2:0]       res_pc_q;
  logic [39:0]      name_q;
  logic [3:0]       len_q;
  logic [CHR_W-1:0] k_q;
  logic [IDX_W-1:0] scan_idx_q;
  logic [31:0]      rd_data_q;
  logic [31:0]      mem [TABLE_DEPTH];
  logic             out_valid_q;
  cld_out_t         out_q, out_d;
  logic [7:0]       name_byte;
  logic [TOK_W-1:0] tok_pc;

  // Hold the terminator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= TERM_DEFAULT;
    end else if (cfg_valid_i && cfg_ready_i) begin
      term_q <= cfg_data_i;
    end
  end

  // Advance the line state for one ordinary character
  always_comb begin
    hash_d   = hash_q;
    tok_d    = tok_q;
    in_tok_d = in_tok_q;
    zero_d   = zero_q;
    if (!zero_q) begin
      if (in_data_i.char_value == 8'd0) begin
        zero_d = 1'b1;
      end else if (in_data_i.char_value == CHAR_SPACE ||
                   in_data_i.char_value == CHAR_TAB) begin
        in_tok_d = 1'b0;
      end else begin
        if (!in_tok_q) begin
          in_tok_d = 1'b1;
          if (tok_q < TOK_W'(MAX_PARAMS + 1)) begin
            tok_d = tok_q + TOK_W'(1);
          end
        end
        if (tok_d == TOK_W'(1)) begin
          hash_d = hash_step(hash_q, in_data_i.char_value);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= HASH_START;
      tok_q    <= '0;
      in_tok_q <= 1'b0;
      zero_q   <= 1'b0;
    end else if (cmd_i.load_line) begin
      hash_q   <= HASH_START;
      tok_q    <= '0;
      in_tok_q <= 1'b0;
      zero_q   <= 1'b0;
    end else if (cmd_i.step_char) begin
      hash_q   <= hash_d;
      tok_q    <= tok_d;
      in_tok_q <= in_tok_d;
      zero_q   <= zero_d;
    end
  end

  // Parameter count of the finished line, tokens after the command
  assign tok_pc = tok_q - TOK_W'(1);

  // Pick the next name byte; beyond the name the shift yields zero
  assign name_byte = 8'(name_q >> {k_q, 3'b000});

  // Work registers for hashing a name or holding a finished line
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      work_hash_q <= hash_q;
      res_pc_q    <= 3'(tok_pc);
    end else if (cmd_i.load_reg) begin
      work_hash_q <= HASH_START;
      name_q      <= in_data_i.name_bytes;
      len_q       <= in_data_i.name_length;
      k_q         <= '0;
    end else if (cmd_i.reg_step) begin
      work_hash_q <= hash_step(work_hash_q, name_byte);
      k_q         <= k_q + CHR_W'(1);
    end
  end

  // Step the scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_inc) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
    end
  end

  // Command table: append on registration, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && cmd_i.res_st == ST_REGISTERED) begin
      mem[count_q[IDX_W-1:0]] <= work_hash_q;
    end
    if (cmd_i.scan_read) begin
      rd_data_q <= mem[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.out_load && cmd_i.res_st == ST_REGISTERED) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Build the result
  always_comb begin
    out_d = '0;
    out_d.status = cmd_i.res_st;
    case (cmd_i.res_st)
      ST_MATCHED: begin
        out_d.entry_index  = 4'(scan_idx_q);
        out_d.param_count  = res_pc_q;
        out_d.command_hash = work_hash_q;
      end
      ST_UNKNOWN: begin
        out_d.param_count  = res_pc_q;
        out_d.command_hash = work_hash_q;
      end
      ST_REGISTERED: begin
        out_d.entry_index  = 4'(count_q);
        out_d.command_hash = work_hash_q;
      end
      default: begin
        out_d.entry_index  = '0;
      end
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  assign sts_o.is_reg      = in_data_i.command;
  assign sts_o.is_term     = (in_data_i.char_value == term_q);
  assign sts_o.line_empty  = (tok_q == '0);
  assign sts_o.reg_reject  = (in_data_i.name_length > 4'(MAX_NAME_CHARS)) ||
                             (count_q >= CNT_W'(TABLE_DEPTH));
  assign sts_o.table_empty = (count_q == '0);
  assign sts_o.reg_done    = !({1'b0, k_q} < len_q) || (name_byte == 8'd0);
  assign sts_o.scan_hit    = (rd_data_q == work_hash_q);
  assign sts_o.scan_last   = (({1'b0, scan_idx_q} + CNT_W'(1)) >= count_q);
  assign sts_o.slot_free   = !out_valid_q || !out_stall_i;

  // A result never overwrites one that is still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting result");

  // The table never grows past its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Scans read only written entries
  a_scan_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_read |-> ({1'b0, scan_idx_q} < count_q))
    else $error("scan reads an unwritten entry");

endmodule

`default_nettype wire

### hw/rtl/cld_ctrl.sv
// Controller: sequences character, terminator and registration requests.
`default_nettype none

module cld_ctrl import cld_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cld_sts_t sts_i,
  output cld_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_REG_HASH = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CMP = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  logic    accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res_st = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.is_reg) begin
            if (sts_i.reg_reject) begin
              res_d   = ST_REJECTED;
              state_d = S_DONE;
            end else begin
              cmd_o.load_reg = 1'b1;
              state_d = S_REG_HASH;
            end
          end else if (sts_i.is_term) begin
            cmd_o.load_line = 1'b1;
            cmd_o.scan_clr  = 1'b1;
            if (sts_i.line_empty) begin
              res_d   = ST_EMPTY;
              state_d = S_DONE;
            end else if (sts_i.table_empty) begin
              res_d   = ST_UNKNOWN;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end else begin
            cmd_o.step_char = 1'b1;
          end
        end
      end
      S_REG_HASH: begin
        if (sts_i.reg_done) begin
          res_d   = ST_REGISTERED;
          state_d = S_DONE;
        end else begin
          cmd_o.reg_step = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_read = 1'b1;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.scan_hit) begin
          res_d   = ST_MATCHED;
          state_d = S_DONE;
        end else if (sts_i.scan_last) begin
          res_d   = ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_EMPTY;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/command_line_hash_dispatcher.sv
// Top level of the command line hash dispatcher.
`default_nettype none

// Ordinary line characters are taken one per cycle while the controller is
// idle and update the djb2 hash of the first token and the parameter count
// in that cycle. A terminator request starts a scan of the command table,
// reading each entry in S_SCAN_RD through the table memory's registered read
// port and comparing it in S_SCAN_CMP; the scan stops at the first hit or at
// the last entry. An empty line, a line met with an empty table and a
// rejected registration go straight to S_DONE without a scan or hashing. A
// registration request hashes its name one character a cycle, up to its
// length or its first zero byte. Each request that gives a result sits in an
// output register until taken; a new request is taken as soon as the previous
// one has handed its result to that register, so a result still waiting
// there holds back the following requests by its stall. The terminator byte
// register resets to 10 and is written through the configuration port, which
// is always ready. The table needs no clearing after reset.
module command_line_hash_dispatcher import cld_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire cld_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output cld_out_t        out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  cld_cmd_t cmd;
  cld_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cld_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### dv/tb_command_line_hash_dispatcher.sv
// Self-checking testbench for the command line hash dispatcher.
`timescale 1ns / 1ps

module tb_command_line_hash_dispatcher;
  import cld_pkg::*;

  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + MAX_NAME_CHARS + 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 280;

  typedef struct {
    cld_in_t  req;
    bit       typed;
    cld_out_t want;
  } script_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  cld_in_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  cld_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  // Line state and command table as the dispatcher should hold them
  logic [31:0] line_hash;
  int          line_tokens;
  bit          in_word;
  bit          nul_seen;
  logic [31:0] known_hashes [TABLE_DEPTH];
  int          known_count;
  logic [7:0]  term_byte;

  cld_out_t    pending_results [$];
  cld_out_t    head_result;
  script_row_t opening_script [$];
  logic [39:0] word_bank [$];
  int          word_bank_len [$];
  logic [7:0]  phase_terms [5];
  int          items_sent;
  int          mismatches;
  int          idle_pct;
  int          quiet_cycles;

  command_line_hash_dispatcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic void clear_line();
    line_hash   = HASH_START;
    line_tokens = 0;
    in_word     = 1'b0;
    nul_seen    = 1'b0;
  endfunction

  // Compute the result, if any, of one request and advance the line and table state
  function automatic void predict_request(input cld_in_t req, output bit gives,
                                          output cld_out_t res);
    logic [31:0] h;
    logic [7:0]  c;
    bit          stop;
    bit          hit;
    int          k;
    int          pc;
    gives = 1'b0;
    res   = '0;
    c     = req.char_value;
    if (req.command) begin
      gives = 1'b1;
      if (req.name_length > MAX_NAME_CHARS || known_count >= TABLE_DEPTH) begin
        res.status = ST_REJECTED;
      end else begin
        h    = HASH_START;
        stop = 1'b0;
        for (k = 0; k < req.name_length; k++) begin
          if (req.name_bytes[8*k +: 8] == 8'h00) stop = 1'b1;
          if (!stop) h = h * 32'd33 + {24'd0, req.name_bytes[8*k +: 8]};
        end
        known_hashes[known_count] = h;
        res.status       = ST_REGISTERED;
        res.entry_index  = 4'(known_count);
        res.command_hash = h;
        known_count++;
      end
    end else if (c == term_byte) begin
      gives = 1'b1;
      if (line_tokens == 0) begin
        res.status = ST_EMPTY;
      end else begin
        pc = line_tokens - 1;
        if (pc > MAX_PARAMS) pc = MAX_PARAMS;
        hit        = 1'b0;
        res.status = ST_UNKNOWN;
        for (k = 0; k < known_count; k++) begin
          if (!hit && known_hashes[k] == line_hash) begin
            hit             = 1'b1;
            res.status      = ST_MATCHED;
            res.entry_index = 4'(k);
          end
        end
        res.param_count  = 3'(pc);
        res.command_hash = line_hash;
      end
      clear_line();
    end else if (!nul_seen) begin
      if (c == 8'h00) begin
        nul_seen = 1'b1;
      end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
        in_word = 1'b0;
      end else begin
        if (!in_word) begin
          in_word = 1'b1;
          if (line_tokens < MAX_PARAMS + 1) line_tokens++;
        end
        if (line_tokens == 1) line_hash = line_hash * 32'd33 + {24'd0, c};
      end
    end
  endfunction

  function automatic cld_in_t line_req(logic [7:0] c);
    cld_in_t req;
    req.command     = 1'b0;
    req.char_value  = c;
    req.name_bytes  = 40'({$urandom, $urandom});
    req.name_length = 4'($urandom);
    return req;
  endfunction

  function automatic cld_in_t name_req(logic [39:0] nm, logic [3:0] len);
    cld_in_t req;
    req.command     = 1'b1;
    req.char_value  = 8'($urandom);
    req.name_bytes  = nm;
    req.name_length = len;
    return req;
  endfunction

  function automatic cld_out_t result_of(status_e st, logic [3:0] idx, logic [2:0] pc,
                                         logic [31:0] h);
    cld_out_t res;
    res.status       = st;
    res.entry_index  = idx;
    res.param_count  = pc;
    res.command_hash = h;
    return res;
  endfunction

  function automatic void add_row(cld_in_t req, bit typed, cld_out_t want);
    script_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    opening_script.push_back(row);
  endfunction

  // Pick a token character that is neither a delimiter, a zero byte nor the terminator
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(33, 126));
    end while (c == CHAR_SPACE || c == CHAR_TAB || c == term_byte);
    return c;
  endfunction

  function automatic logic [7:0] delim_char();
    if (term_byte == CHAR_SPACE) return CHAR_TAB;
    if (term_byte == CHAR_TAB) return CHAR_SPACE;
    return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one request, hold it until taken, then record what it should produce
  task automatic send_request(input cld_in_t req, input bit typed, input cld_out_t want);
    bit       gives;
    cld_out_t res;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_request(req, gives, res);
    if (gives) pending_results.push_back(typed ? want : res);
    items_sent++;
  endtask

  task automatic send_registration();
    logic [39:0] nm;
    logic [39:0] w;
    int          len;
    int          r;
    int          j;
    int          pick;
    int          eff;
    nm = 40'({$urandom, $urandom});
    r  = $urandom_range(0, 99);
    if (r < 15) begin
      len = $urandom_range(MAX_NAME_CHARS + 1, 15);
    end else if (r < 40 && word_bank.size() != 0) begin
      // Register a duplicate name
      pick = $urandom_range(0, word_bank.size() - 1);
      len  = word_bank_len[pick];
      for (j = 0; j < len; j++) nm[8*j +: 8] = word_bank[pick][8*j +: 8];
    end else begin
      len = $urandom_range(0, MAX_NAME_CHARS);
      for (j = 0; j < len; j++) nm[8*j +: 8] = word_char();
      if (len > 1 && $urandom_range(0, 9) == 0) begin
        pick = $urandom_range(1, len - 1);
        nm[8*pick +: 8] = 8'h00;
      end
      eff = 0;
      while (eff < len && nm[8*eff +: 8] != 8'h00) eff++;
      if (eff > 0) begin
        w = '0;
        for (j = 0; j < eff; j++) w[8*j +: 8] = nm[8*j +: 8];
        word_bank.push_back(w);
        word_bank_len.push_back(eff);
      end
    end
    send_request(name_req(nm, 4'(len)), 1'b0, '0);
  endtask

  // Send one line character, now and then preceded by a registration
  task automatic send_char(logic [7:0] c);
    if ($urandom_range(0, 49) == 0) send_registration();
    send_request(line_req(c), 1'b0, '0);
  endtask

  task automatic send_word(logic [39:0] w, int len);
    int j;
    for (j = 0; j < len; j++) send_char(w[8*j +: 8]);
  endtask

  task automatic send_random_word();
    logic [39:0] w;
    int          len;
    int          j;
    w   = '0;
    len = $urandom_range(1, MAX_NAME_CHARS);
    for (j = 0; j < len; j++) w[8*j +: 8] = word_char();
    send_word(w, len);
  endtask

  // Send a line: optional leading delimiters, an optional command with parameters, terminator
  task automatic send_line();
    int k;
    int pick;
    int n_params;
    repeat ($urandom_range(0, 2)) send_char(delim_char());
    if ($urandom_range(0, 9) != 0) begin
      if (word_bank.size() != 0 && $urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, word_bank.size() - 1);
        send_word(word_bank[pick], word_bank_len[pick]);
      end else begin
        send_random_word();
      end
      n_params = $urandom_range(0, MAX_PARAMS + 2);
      for (k = 0; k < n_params; k++) begin
        repeat ($urandom_range(1, 2)) send_char(delim_char());
        send_random_word();
      end
    end
    // Cut the line short with a zero byte and trailing garbage
    if ($urandom_range(0, 9) == 0) begin
      send_char(8'h00);
      repeat ($urandom_range(0, 3)) send_char(word_char());
    end
    if ($urandom_range(0, 3) == 0) send_char(delim_char());
    send_char(term_byte);
  endtask

  // Drain the block, then write the terminator byte
  task automatic write_terminator(logic [7:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    term_byte = value;
  endtask

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  // Check each taken result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 64'(out_data_o), '0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_data_o.status !== head_result.status)
          flag_mismatch("status", 64'(out_data_o.status), 64'(head_result.status));
        if (out_data_o.entry_index !== head_result.entry_index)
          flag_mismatch("entry_index", 64'(out_data_o.entry_index),
                        64'(head_result.entry_index));
        if (out_data_o.param_count !== head_result.param_count)
          flag_mismatch("param_count", 64'(out_data_o.param_count),
                        64'(head_result.param_count));
        if (out_data_o.command_hash !== head_result.command_hash)
          flag_mismatch("command_hash", 64'(out_data_o.command_hash),
                        64'(head_result.command_hash));
      end
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_command_line_hash_dispatcher failed");
      $finish;
    end
  end

  initial begin
    int          phase;
    int          phase_end;
    int          r;
    int          reg_pct;
    script_row_t row;
    cld_out_t    none;
    none         = '0;
    quiet_cycles = 0;
    items_sent   = 0;
    mismatches   = 0;
    idle_pct     = 20;
    known_count  = 0;
    term_byte    = TERM_DEFAULT;
    clear_line();

    phase_terms[0] = 8'h00;
    phase_terms[1] = 8'hFF;
    phase_terms[2] = CHAR_SPACE;
    phase_terms[3] = 8'($urandom);
    phase_terms[4] = TERM_DEFAULT;

    // Opening script: empty line, rejections, registrations and a few lookups
    add_row(line_req(TERM_DEFAULT), 1'b1, result_of(ST_EMPTY, 0, 0, 0));
    add_row(name_req(40'h6665646362, 4'd6), 1'b1, result_of(ST_REJECTED, 0, 0, 0));
    add_row(name_req(40'hFFFFFFFFFF, 4'd15), 1'b1, result_of(ST_REJECTED, 0, 0, 0));
    add_row(name_req(40'hA5A5A5A5A5, 4'd0), 1'b1, result_of(ST_REGISTERED, 0, 0, HASH_START));
    add_row(name_req(40'hFFFFFF6261, 4'd2), 1'b0, none);
    add_row(name_req(40'hFFFFFFFFFF, 4'd5), 1'b0, none);
    add_row(name_req(40'hFFFF640063, 4'd3), 1'b0, none);
    add_row(line_req(CHAR_SPACE), 1'b0, none);
    add_row(line_req(CHAR_TAB), 1'b0, none);
    add_row(line_req("a"), 1'b0, none);
    add_row(line_req("b"), 1'b0, none);
    add_row(line_req(CHAR_SPACE), 1'b0, none);
    add_row(line_req("x"), 1'b0, none);
    add_row(name_req(40'h0000006261, 4'd2), 1'b0, none);
    add_row(line_req(CHAR_TAB), 1'b0, none);
    add_row(line_req(8'h00), 1'b0, none);
    add_row(line_req("y"), 1'b0, none);
    add_row(line_req(TERM_DEFAULT), 1'b0, none);
    add_row(line_req(8'hFF), 1'b0, none);
    add_row(line_req(TERM_DEFAULT), 1'b0, none);
    add_row(line_req("c"), 1'b0, none);
    add_row(line_req(TERM_DEFAULT), 1'b0, none);
    add_row(line_req(8'h00), 1'b0, none);
    add_row(line_req("k"), 1'b0, none);
    add_row(line_req(TERM_DEFAULT), 1'b1, result_of(ST_EMPTY, 0, 0, 0));

    // Hold reset, then release it on a clock edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_terminator(TERM_DEFAULT);
    foreach (opening_script[i]) begin
      row = opening_script[i];
      send_request(row.req, row.typed, row.want);
    end
    word_bank.push_back(40'h0000006261);
    word_bank_len.push_back(2);
    word_bank.push_back(40'h0000000063);
    word_bank_len.push_back(1);

    // Random phases, one per terminator setting; the second runs without idling
    for (phase = 0; phase < 5; phase++) begin
      write_terminator(phase_terms[phase]);
      idle_pct  = (phase == 1) ? 0 : 20;
      reg_pct   = (phase == 0) ? 30 : 12;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          repeat ($urandom_range(1, 4)) send_char(8'($urandom));
        end else if (r < 8 + reg_pct) begin
          send_registration();
        end else begin
          send_line();
        end
      end
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_command_line_hash_dispatcher passed");
    end else begin
      $display("tb_command_line_hash_dispatcher failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cld_pkg.sv
hw/rtl/cld_dp.sv
hw/rtl/cld_ctrl.sv
hw/rtl/command_line_hash_dispatcher.sv
dv/tb_command_line_hash_dispatcher.sv
